[hdl/rchs_pkg.sv]
`timescale 1ns / 1ps
package rchs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 52;
    localparam int DEN_W     = 33;
    localparam int QUO_W     = 32;
    localparam int IN_W      = 240;
    localparam int OUT_W     = 200;

    localparam logic signed [17:0] ONE_Q    = 18'(64'd1 << FRAC_BITS);
    localparam logic [30:0]        HALF_Q   = 31'(64'd1 << (FRAC_BITS - 1));
    localparam logic [30:0]        MAXD_RST = 31'h7FFF_FFFF;

    localparam logic [2:0] CFG_ORG_X = 3'd0;
    localparam logic [2:0] CFG_ORG_Y = 3'd1;
    localparam logic [2:0] CFG_ORG_Z = 3'd2;
    localparam logic [2:0] CFG_DIR_X = 3'd3;
    localparam logic [2:0] CFG_DIR_Y = 3'd4;
    localparam logic [2:0] CFG_DIR_Z = 3'd5;
    localparam logic [2:0] CFG_MAXD  = 3'd6;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SLAB_CHK, OP_DIV_LO, OP_T1_HI, OP_SLAB_UPD, OP_BOX_END,
        OP_PT_MUL, OP_PT_ADD, OP_SPH_OC, OP_DOT_MUL, OP_SQ_MUL, OP_ACC, OP_BD,
        OP_RR_MUL, OP_CC, OP_BB_MUL, OP_DISC, OP_SQRT_DISC, OP_SPH_T, OP_DF,
        OP_SQRT_SUM, OP_LEN, OP_DIV_N, OP_N_SAVE, OP_N_ZERO, OP_COMMIT, OP_EMIT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_KIND, S_BOX_AX, S_WAIT_LO, S_WAIT_HI, S_BOX_NEXT, S_BOX_END,
        S_HIT_CHK, S_PT_MUL, S_PT_ADD, S_SPH_OC, S_DOT_MUL, S_DOT_ACC, S_BD,
        S_SS_MUL, S_SS_ACC, S_RR, S_CC, S_BB, S_DISC, S_DISC_CHK, S_WAIT_SQ1,
        S_DF, S_DF_MUL, S_DF_ACC, S_SQ2, S_WAIT_SQ2, S_N_START, S_WAIT_N,
        S_N_NEXT, S_COMMIT, S_EMIT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] ax;
    } cmd_t;

    typedef struct packed {
        logic is_box;
        logic dir_zero;
        logic miss;
        logic hit;
        logic last;
        logic div_busy;
        logic sqrt_busy;
        logic len_zero;
        logic out_busy;
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -68'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage

[hdl/rchs_div.sv]
`timescale 1ns / 1ps
module rchs_div
    import rchs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    busy,
    output logic signed [QUO_W-1:0] quo
);

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic             ovf;
    logic [DEN_W:0]   trial;
    logic             qbit;

    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] low_reg;
    logic [DEN_W-1:0] den_reg;
    logic             neg_reg;
    logic             ovf_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;

    always_comb begin
        num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        ovf     = (65'(num_mag) >= {den_mag, 32'd0});
        trial   = {rem_reg, low_reg[QUO_W-1]};
        qbit    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            rem_reg  <= DEN_W'(num_mag >> QUO_W);
            low_reg  <= num_mag[QUO_W-1:0];
            den_reg  <= den_mag;
            neg_reg  <= num[NUM_W-1] ^ den[DEN_W-1];
            ovf_reg  <= ovf;
            busy_reg <= !ovf;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg  <= qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            low_reg  <= {low_reg[QUO_W-2:0], qbit};
            cnt_reg  <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(QUO_W - 1)) busy_reg <= 1'b0;
        end
    end

    // truncate toward zero, saturate to the signed 32-bit range
    always_comb begin
        if (ovf_reg)
            quo = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (neg_reg)
            quo = (low_reg > 32'h8000_0000) ? 32'sh8000_0000 : 32'(-{1'b0, low_reg});
        else
            quo = low_reg[QUO_W-1] ? 32'sh7FFF_FFFF : $signed(low_reg);
    end

    assign busy = busy_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider restarted while busy");

endmodule

[hdl/rchs_sqrt.sv]
`timescale 1ns / 1ps
module rchs_sqrt
    import rchs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] arg,
    output logic        busy,
    output logic [31:0] root
);

    logic [35:0] rem2;
    logic [35:0] trial;
    logic        take;

    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [63:0] arg_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;

    always_comb begin
        rem2  = {rem_reg, arg_reg[63:62]};
        trial = 36'({root_reg, 2'b01});
        take  = (rem2 >= trial);
    end

    // two radicand bits per cycle, one root bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            rem_reg  <= '0;
            root_reg <= '0;
            arg_reg  <= arg;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg  <= take ? 34'(rem2 - trial) : rem2[33:0];
            root_reg <= {root_reg[30:0], take};
            arg_reg  <= {arg_reg[61:0], 2'b00};
            cnt_reg  <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("root unit restarted while busy");

endmodule

[hdl/rchs_dpath.sv]
`timescale 1ns / 1ps
module rchs_dpath
    import rchs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_wdata,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tlast,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser
);

    logic signed [31:0] org_reg [3];
    logic signed [17:0] dir_reg [3];
    logic [30:0]        maxd_reg;

    logic signed [31:0] cen_reg [3];
    logic [30:0]        hlf_reg [3];
    logic [30:0]        rad_reg;
    logic [15:0]        bid_reg;
    logic               last_reg;
    logic               box_reg;

    logic signed [31:0] tmin_reg, tmax_reg, t1_reg;
    logic [30:0]        tcur_reg;
    logic signed [17:0] ncur_reg [3];
    logic               miss_reg, hit_reg;
    logic signed [31:0] vec_reg [3];
    logic signed [31:0] pt_reg [3];
    logic signed [64:0] acc_reg;
    logic signed [31:0] bd_reg;
    logic signed [50:0] disc_reg;
    logic [31:0]        len_reg;
    logic signed [65:0] mul_reg;

    logic               any_hit_reg;
    logic [30:0]        best_d_reg;
    logic signed [31:0] best_p_reg [3];
    logic signed [17:0] best_n_reg [3];
    logic [15:0]        best_b_reg;

    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg;
    logic               m_user_reg;

    logic [1:0]         ax;
    logic signed [31:0] o_ax, quo, near_t, far_t, tmin_c, tmax_c, best_s;
    logic signed [17:0] d_ax;
    logic signed [33:0] lo_c, hi_c, tsph;
    logic signed [34:0] diff_lo, diff_hi;
    logic               swap;
    logic signed [32:0] mul_a, mul_b;
    logic               div_start, div_busy, sq_start, sq_busy;
    logic signed [NUM_W-1:0] div_num;
    logic signed [DEN_W-1:0] div_den;
    logic [63:0]        sq_arg;
    logic [31:0]        root;
    logic signed [50:0] disc_c;

    always_comb begin
        ax      = cmd.ax;
        o_ax    = org_reg[ax];
        d_ax    = dir_reg[ax];
        lo_c    = 34'(cen_reg[ax]) - 34'($signed({1'b0, hlf_reg[ax]}));
        hi_c    = 34'(cen_reg[ax]) + 34'($signed({1'b0, hlf_reg[ax]}));
        diff_lo = 35'(lo_c) - 35'(o_ax);
        diff_hi = 35'(hi_c) - 35'(o_ax);
        swap    = (t1_reg > quo);
        near_t  = swap ? quo : t1_reg;
        far_t   = swap ? t1_reg : quo;
        tmin_c  = (near_t > tmin_reg) ? near_t : tmin_reg;
        tmax_c  = (far_t < tmax_reg) ? far_t : tmax_reg;
        best_s  = $signed({1'b0, best_d_reg});
        disc_c  = 51'(mul_reg >>> FRAC_BITS) - disc_reg;
        tsph    = -34'(bd_reg) - 34'($signed({2'b00, root}));

        div_start = 1'b0;
        div_num   = '0;
        div_den   = 33'(d_ax);
        sq_start  = 1'b0;
        sq_arg    = acc_reg[63:0];
        mul_a     = '0;
        mul_b     = '0;
        case (cmd.op)
            OP_DIV_LO: begin
                div_start = 1'b1;
                div_num   = NUM_W'(diff_lo) <<< FRAC_BITS;
            end
            OP_T1_HI: begin
                div_start = 1'b1;
                div_num   = NUM_W'(diff_hi) <<< FRAC_BITS;
            end
            OP_DIV_N: begin
                div_start = 1'b1;
                div_num   = NUM_W'(vec_reg[ax]) <<< FRAC_BITS;
                div_den   = $signed({1'b0, len_reg});
            end
            OP_SQRT_DISC: begin
                sq_start = 1'b1;
                sq_arg   = 64'(disc_reg) << FRAC_BITS;
            end
            OP_SQRT_SUM: sq_start = 1'b1;
            OP_PT_MUL: begin
                mul_a = 33'(d_ax);
                mul_b = $signed({2'b00, tcur_reg});
            end
            OP_DOT_MUL: begin
                mul_a = 33'(vec_reg[ax]);
                mul_b = 33'(d_ax);
            end
            OP_SQ_MUL: begin
                mul_a = 33'(vec_reg[ax]);
                mul_b = 33'(vec_reg[ax]);
            end
            OP_RR_MUL: begin
                mul_a = $signed({2'b00, rad_reg});
                mul_b = $signed({2'b00, rad_reg});
            end
            OP_BB_MUL: begin
                mul_a = 33'(bd_reg);
                mul_b = 33'(bd_reg);
            end
            default: ;
        endcase
    end

    rchs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (quo)
    );

    rchs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .arg     (sq_arg),
        .busy    (sq_busy),
        .root    (root)
    );

    always_ff @(posedge aclk) begin
        mul_reg <= mul_a * mul_b;
    end

    // working registers of one body
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                cen_reg[0]  <= $signed(s_tdata[31:0]);
                cen_reg[1]  <= $signed(s_tdata[63:32]);
                cen_reg[2]  <= $signed(s_tdata[95:64]);
                hlf_reg[0]  <= s_tdata[126:96];
                hlf_reg[1]  <= s_tdata[157:127];
                hlf_reg[2]  <= s_tdata[188:158];
                rad_reg     <= s_tdata[220] ? s_tdata[219:189] : HALF_Q;
                bid_reg     <= s_tdata[236:221];
                last_reg    <= s_tlast;
                box_reg     <= |s_tdata[188:96];
                tmin_reg    <= '0;
                tmax_reg    <= best_s;
                ncur_reg[0] <= '0;
                ncur_reg[1] <= ONE_Q;
                ncur_reg[2] <= '0;
                miss_reg    <= 1'b0;
                hit_reg     <= 1'b0;
            end
            OP_SLAB_CHK: begin
                if (34'(o_ax) < lo_c || 34'(o_ax) > hi_c) miss_reg <= 1'b1;
            end
            OP_T1_HI: t1_reg <= quo;
            OP_SLAB_UPD: begin
                if (near_t > tmin_reg) begin
                    ncur_reg[0]  <= '0;
                    ncur_reg[1]  <= '0;
                    ncur_reg[2]  <= '0;
                    ncur_reg[ax] <= swap ? ONE_Q : -ONE_Q;
                end
                tmin_reg <= tmin_c;
                tmax_reg <= tmax_c;
                if (tmin_c > tmax_c) miss_reg <= 1'b1;
            end
            OP_BOX_END: begin
                if (!miss_reg && tmin_reg > 0 && tmin_reg <= best_s) begin
                    hit_reg  <= 1'b1;
                    tcur_reg <= tmin_reg[30:0];
                end
            end
            OP_PT_ADD: pt_reg[ax] <= sat32(68'(o_ax) + 68'(mul_reg >>> FRAC_BITS));
            OP_SPH_OC: begin
                for (int a = 0; a < 3; a++)
                    vec_reg[a] <= sat32(68'(org_reg[a]) - 68'(cen_reg[a]));
                acc_reg <= '0;
            end
            OP_ACC: acc_reg <= acc_reg + 65'(mul_reg);
            OP_BD: begin
                bd_reg  <= sat32(68'(acc_reg >>> FRAC_BITS));
                acc_reg <= '0;
            end
            // the sum of squares wraps at 64 bits
            OP_CC: disc_reg <= 51'(acc_reg[63:FRAC_BITS]) - 51'(mul_reg >>> FRAC_BITS);
            OP_DISC: begin
                disc_reg <= disc_c;
                if (disc_c < 0) miss_reg <= 1'b1;
            end
            OP_SPH_T: begin
                if (tsph > 0 && tsph <= 34'(best_s)) begin
                    hit_reg  <= 1'b1;
                    tcur_reg <= tsph[30:0];
                end
            end
            OP_DF: begin
                for (int a = 0; a < 3; a++)
                    vec_reg[a] <= sat32(68'(pt_reg[a]) - 68'(cen_reg[a]));
                acc_reg <= '0;
            end
            OP_LEN:    len_reg <= root;
            OP_N_SAVE: ncur_reg[ax] <= quo[17:0];
            OP_N_ZERO: ncur_reg[ax] <= '0;
            default: ;
        endcase
    end

    // ray configuration, running best hit and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0]  <= '0;
            org_reg[1]  <= '0;
            org_reg[2]  <= '0;
            dir_reg[0]  <= ONE_Q;
            dir_reg[1]  <= '0;
            dir_reg[2]  <= '0;
            maxd_reg    <= MAXD_RST;
            any_hit_reg <= 1'b0;
            best_d_reg  <= MAXD_RST;
            for (int a = 0; a < 3; a++) begin
                best_p_reg[a] <= '0;
                best_n_reg[a] <= '0;
            end
            best_b_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ORG_X: org_reg[0] <= $signed(cfg_wdata);
                    CFG_ORG_Y: org_reg[1] <= $signed(cfg_wdata);
                    CFG_ORG_Z: org_reg[2] <= $signed(cfg_wdata);
                    CFG_DIR_X: dir_reg[0] <= $signed(cfg_wdata[17:0]);
                    CFG_DIR_Y: dir_reg[1] <= $signed(cfg_wdata[17:0]);
                    CFG_DIR_Z: dir_reg[2] <= $signed(cfg_wdata[17:0]);
                    CFG_MAXD: begin
                        maxd_reg <= cfg_wdata[30:0];
                        if (!any_hit_reg) best_d_reg <= cfg_wdata[30:0];
                    end
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            case (cmd.op)
                OP_COMMIT: begin
                    if (hit_reg) begin
                        any_hit_reg <= 1'b1;
                        best_d_reg  <= tcur_reg;
                        best_p_reg  <= pt_reg;
                        best_n_reg  <= ncur_reg;
                        best_b_reg  <= bid_reg;
                    end
                end
                OP_EMIT: begin
                    m_valid_reg <= 1'b1;
                    m_user_reg  <= any_hit_reg;
                    m_data_reg  <= {3'b000, best_b_reg, best_n_reg[2], best_n_reg[1],
                                    best_n_reg[0], best_p_reg[2], best_p_reg[1],
                                    best_p_reg[0], best_d_reg};
                    any_hit_reg <= 1'b0;
                    best_d_reg  <= maxd_reg;
                    for (int a = 0; a < 3; a++) begin
                        best_p_reg[a] <= '0;
                        best_n_reg[a] <= '0;
                    end
                    best_b_reg  <= '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        sts.is_box    = box_reg;
        sts.dir_zero  = (d_ax == 0);
        sts.miss      = miss_reg;
        sts.hit       = hit_reg;
        sts.last      = last_reg;
        sts.div_busy  = div_busy;
        sts.sqrt_busy = sq_busy;
        sts.len_zero  = (len_reg == 0);
        sts.out_busy  = m_valid_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_best_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        any_hit_reg |-> (best_d_reg != 0)) else $error("held hit at zero distance");
    a_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_COMMIT && hit_reg) |=> any_hit_reg) else $error("hit not kept");
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |=> (m_valid_reg && !any_hit_reg))
        else $error("emit did not load result and clear state");

endmodule

[hdl/rchs_ctrl.sv]
`timescale 1ns / 1ps
module rchs_ctrl
    import rchs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t     state_reg, state_next;
    logic [1:0] ax_reg, ax_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ax_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ax_next    = ax_reg;
        cmd.op     = OP_NONE;
        cmd.ax     = ax_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_KIND;
                end
            end
            S_KIND: begin
                ax_next    = '0;
                state_next = sts.is_box ? S_BOX_AX : S_SPH_OC;
            end
            S_BOX_AX: begin
                if (sts.dir_zero) begin
                    cmd.op     = OP_SLAB_CHK;
                    state_next = S_BOX_NEXT;
                end else begin
                    cmd.op     = OP_DIV_LO;
                    state_next = S_WAIT_LO;
                end
            end
            S_WAIT_LO: if (!sts.div_busy) begin
                cmd.op     = OP_T1_HI;
                state_next = S_WAIT_HI;
            end
            S_WAIT_HI: if (!sts.div_busy) begin
                cmd.op     = OP_SLAB_UPD;
                state_next = S_BOX_NEXT;
            end
            S_BOX_NEXT: begin
                if (sts.miss || ax_reg == 2'd2) state_next = S_BOX_END;
                else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_BOX_AX;
                end
            end
            S_BOX_END: begin
                cmd.op     = OP_BOX_END;
                state_next = S_HIT_CHK;
            end
            S_HIT_CHK: begin
                ax_next    = '0;
                state_next = sts.hit ? S_PT_MUL : S_COMMIT;
            end
            S_PT_MUL: begin
                cmd.op     = OP_PT_MUL;
                state_next = S_PT_ADD;
            end
            S_PT_ADD: begin
                cmd.op = OP_PT_ADD;
                if (ax_reg == 2'd2) state_next = sts.is_box ? S_COMMIT : S_DF;
                else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_PT_MUL;
                end
            end
            S_SPH_OC: begin
                cmd.op     = OP_SPH_OC;
                ax_next    = '0;
                state_next = S_DOT_MUL;
            end
            S_DOT_MUL: begin
                cmd.op     = OP_DOT_MUL;
                state_next = S_DOT_ACC;
            end
            S_DOT_ACC: begin
                cmd.op = OP_ACC;
                if (ax_reg == 2'd2) state_next = S_BD;
                else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_DOT_MUL;
                end
            end
            S_BD: begin
                cmd.op     = OP_BD;
                ax_next    = '0;
                state_next = S_SS_MUL;
            end
            S_SS_MUL: begin
                cmd.op     = OP_SQ_MUL;
                state_next = S_SS_ACC;
            end
            S_SS_ACC: begin
                cmd.op = OP_ACC;
                if (ax_reg == 2'd2) state_next = S_RR;
                else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_SS_MUL;
                end
            end
            S_RR: begin
                cmd.op     = OP_RR_MUL;
                state_next = S_CC;
            end
            S_CC: begin
                cmd.op     = OP_CC;
                state_next = S_BB;
            end
            S_BB: begin
                cmd.op     = OP_BB_MUL;
                state_next = S_DISC;
            end
            S_DISC: begin
                cmd.op     = OP_DISC;
                state_next = S_DISC_CHK;
            end
            S_DISC_CHK: begin
                if (sts.miss) state_next = S_COMMIT;
                else begin
                    cmd.op     = OP_SQRT_DISC;
                    state_next = S_WAIT_SQ1;
                end
            end
            S_WAIT_SQ1: if (!sts.sqrt_busy) begin
                cmd.op     = OP_SPH_T;
                state_next = S_HIT_CHK;
            end
            S_DF: begin
                cmd.op     = OP_DF;
                ax_next    = '0;
                state_next = S_DF_MUL;
            end
            S_DF_MUL: begin
                cmd.op     = OP_SQ_MUL;
                state_next = S_DF_ACC;
            end
            S_DF_ACC: begin
                cmd.op = OP_ACC;
                if (ax_reg == 2'd2) state_next = S_SQ2;
                else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_DF_MUL;
                end
            end
            S_SQ2: begin
                cmd.op     = OP_SQRT_SUM;
                state_next = S_WAIT_SQ2;
            end
            S_WAIT_SQ2: if (!sts.sqrt_busy) begin
                cmd.op     = OP_LEN;
                ax_next    = '0;
                state_next = S_N_START;
            end
            S_N_START: begin
                if (sts.len_zero) begin
                    cmd.op     = OP_N_ZERO;
                    state_next = S_N_NEXT;
                end else begin
                    cmd.op     = OP_DIV_N;
                    state_next = S_WAIT_N;
                end
            end
            S_WAIT_N: if (!sts.div_busy) begin
                cmd.op     = OP_N_SAVE;
                state_next = S_N_NEXT;
            end
            S_N_NEXT: begin
                if (ax_reg == 2'd2) state_next = S_COMMIT;
                else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_N_START;
                end
            end
            S_COMMIT: begin
                cmd.op     = OP_COMMIT;
                state_next = sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: if (!sts.out_busy) begin
                cmd.op     = OP_EMIT;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT) |-> !sts.out_busy) else $error("result overwritten");
    a_load_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_LOAD) |=> (state_reg == S_KIND)) else $error("load not followed");

endmodule

[hdl/ray_closest_hit_sphere_box.sv]
`timescale 1ns / 1ps
// Timing: a box body runs two slab divisions per axis with a nonzero direction, stopping
// at the first axis that misses; a sphere hit runs the discriminant root, the normal
// length root and the normal divisions; a sphere miss runs none, or only the discriminant
// root when the hit is out of range. The one-bit-per-cycle divider and root unit set this.
// Throughput: one body at a time; the next body is taken when the current one is done.
// A last body then loads the result register, waiting first for the previous result
// to drain; the next body is taken while the loaded result waits.
// Reset (aresetn low, synchronous): ray (0,0,0) along +x, range 0x7FFFFFFF, no hit held.
module ray_closest_hit_sphere_box
    import rchs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // configuration writes: index 0..6 = origin x/y/z, dir x/y/z, max distance
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_wdata,
    // body stream
    input  logic             s_tvalid,
    output logic             s_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, sphere_radius,
    // radius_present, body_id, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tlast,   // last_body
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // hit_distance, hit_point_x/y/z, hit_normal_x/y/z, hit_body, zero pad
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser    // hit_found
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: walks slabs or sphere terms; one datapath command a cycle, none while waiting
    rchs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: ray registers, shared multiplier, divider, root unit, best hit, result register
    rchs_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
